[sv/gjr_pkg.sv]
package gjr_pkg;

  // matrix geometry and number format
  localparam int MAX_ROWS  = 8;
  localparam int MAX_COLS  = 8;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;

  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int LC_W    = $clog2(DEPTH + 1);
  localparam int RIW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int WIDE_W  = 2 * DATA_W;

  // divider chain: one quotient bit per cell
  localparam int DQ_W      = DATA_W + FRAC_BITS;
  localparam int DIV_STEPS = DQ_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int COUNT_IN_W = 4;
  localparam int THR_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_THRESHOLD = CFG_IDX_W'(2);

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [AW-1:0]            addr_t;

  localparam cnt_t RESET_ROWS = CNT_W'((8 > MAX_ROWS) ? MAX_ROWS : 8);
  localparam cnt_t RESET_COLS = CNT_W'((8 > MAX_COLS) ? MAX_COLS : 8);
  localparam logic [THR_W-1:0] RESET_THR = THR_W'(7);

  localparam q_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_COL,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SWAP_RD_T,
    ST_SWAP_RD_R,
    ST_SWAP_WR_T,
    ST_SWAP_WR_R,
    ST_PIV_RD,
    ST_PIV_SET,
    ST_ELIM_ROW,
    ST_ELIM_DIV,
    ST_ELIM_WAIT,
    ST_UPD_RD_S,
    ST_UPD_RD_D,
    ST_UPD_MUL,
    ST_UPD_SCALE,
    ST_UPD_WR,
    ST_BACK_PIV,
    ST_BACK_PIV_SET,
    ST_BACK_ROW,
    ST_BACK_DIV,
    ST_BACK_WAIT,
    ST_NORM_RD,
    ST_NORM_DIV,
    ST_NORM_WAIT,
    ST_EMIT
  } state_t;

  // one stage of the restoring divider
  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              dz;
    logic              nz;
    logic [DATA_W-1:0] rem;
    logic [DQ_W-1:0]   dq;
    logic [DATA_W-1:0] dvs;
  } div_stage_t;

  function automatic logic [DATA_W-1:0] magnitude(q_t v);
    logic [DATA_W-1:0] u;
    u = v;
    return v[DATA_W-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic is_zero(q_t v, logic [THR_W-1:0] thr);
    return magnitude(v) < {{(DATA_W-THR_W){1'b0}}, thr};
  endfunction

  function automatic q_t sat_wide(wide_t v);
    logic [WIDE_W-DATA_W:0] hi;
    hi = v[WIDE_W-1:DATA_W-1];
    if (hi == '0 || hi == '1) return v[DATA_W-1:0];
    return v[WIDE_W-1] ? Q_MIN : Q_MAX;
  endfunction

  function automatic addr_t cell_addr(cnt_t r, cnt_t c, cnt_t cc);
    logic [2*CNT_W:0] s;
    s = (2*CNT_W+1)'(r) * (2*CNT_W+1)'(cc) + (2*CNT_W+1)'(c);
    return s[AW-1:0];
  endfunction

  function automatic cnt_t clamp_count(logic [COUNT_IN_W-1:0] v, int lim);
    if (v == '0) return CNT_W'(1);
    if (int'(v) > lim) return CNT_W'(lim);
    return CNT_W'(v);
  endfunction

endpackage

[sv/gauss_jordan_rref.sv]
// Gauss-Jordan reduction of a matrix of up to 8 x 8 signed Q16.16 elements to
// reduced row echelon form. Elements are loaded row-major, one per cycle while
// busy is low; the element that completes row_count * col_count starts the
// reduction and busy stays high until the last result element is sent. Every
// division (pivot factors and pivot row normalising) runs through a chain of
// 48 one-bit divider cells. Each updated element passes through the states
// UPD_RD_S, UPD_RD_D, UPD_MUL, UPD_SCALE and UPD_WR around the matrix memory
// and the shared multiplier. A full-rank 8 x 8 matrix needs 92 divisions,
// which set most of its run time.
// The result is then sent row-major, one element per cycle, each with a
// one-cycle result_valid strobe; the receiver cannot stall and must take every
// transfer. The last element carries is_last. Configuration writes are always
// taken (cfg_ready is tied high) and belong to idle periods only.
module gauss_jordan_rref (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [31:0]               element_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gjr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gjr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             result_valid,
  output logic signed [31:0]               result_value,
  output logic [2:0]                       result_row,
  output logic [2:0]                       result_col,
  output logic                             is_last
);

  localparam gjr_pkg::cnt_t ONE = gjr_pkg::CNT_W'(1);
  localparam gjr_pkg::wide_t RND = gjr_pkg::WIDE_W'((64'd1 << gjr_pkg::FRAC_BITS) - 64'd1);

  gjr_pkg::state_t state, state_next;

  // configuration
  gjr_pkg::cnt_t              row_cnt, col_cnt;
  logic [gjr_pkg::THR_W-1:0]  thr;

  // control counters
  logic [gjr_pkg::LC_W-1:0]   load_count;
  gjr_pkg::cnt_t              prow, col, t, cur_i, j, k, pr, pcol, pcnt;
  logic                       back;

  // payload registers
  gjr_pkg::q_t                piv, f, tmp, opa, x, qv;
  gjr_pkg::wide_t             prod;
  logic [gjr_pkg::CIW-1:0]    pivcols [gjr_pkg::MAX_ROWS];
  gjr_pkg::q_t                mem [gjr_pkg::DEPTH];
  gjr_pkg::q_t                rdata;

  // memory port controls
  gjr_pkg::addr_t             raddr, waddr;
  logic                       we;
  gjr_pkg::q_t                wdata;

  // datapath
  logic                       accept;
  logic [gjr_pkg::LC_W-1:0]   lc_inc;
  logic [2*gjr_pkg::CNT_W-1:0] total;
  logic                       load_done;
  gjr_pkg::cnt_t              dst_row, src_row, km1;
  logic                       div_go, div_done;
  gjr_pkg::q_t                div_q;
  gjr_pkg::wide_t             adj, diff;
  gjr_pkg::q_t                upd_val, diff_sat;
  logic                       emit_last;
  logic                       rd_zero;

  assign busy      = state != gjr_pkg::ST_LOAD;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    lc_inc    = load_count + 1'b1;
    total     = (2*gjr_pkg::CNT_W)'(row_cnt) * (2*gjr_pkg::CNT_W)'(col_cnt);
    load_done = 16'(lc_inc) >= 16'(total);
    dst_row   = back ? cur_i - ONE : cur_i;
    src_row   = back ? pr : prow;
    km1       = k - ONE;
    rd_zero   = gjr_pkg::is_zero(rdata, thr);
    emit_last = (cur_i + ONE == row_cnt) && (j + ONE == col_cnt);
  end

  // multiply result scaled toward zero, then subtract and flush
  always_comb begin
    adj      = prod + (prod[gjr_pkg::WIDE_W-1] ? RND : '0);
    diff     = gjr_pkg::WIDE_W'(x) - gjr_pkg::WIDE_W'(qv);
    diff_sat = gjr_pkg::sat_wide(diff);
    upd_val  = gjr_pkg::is_zero(diff_sat, thr) ? '0 : diff_sat;
  end

  // shared divider
  assign div_go = state == gjr_pkg::ST_ELIM_DIV || state == gjr_pkg::ST_BACK_DIV ||
                  state == gjr_pkg::ST_NORM_DIV;

  gjr_div_chain u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (rdata),
    .divisor  (piv),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gjr_pkg::ST_LOAD:
        if (accept && load_done) state_next = gjr_pkg::ST_COL;
      gjr_pkg::ST_COL:
        if (col < col_cnt && prow < row_cnt) state_next = gjr_pkg::ST_SCAN_RD;
        else state_next = gjr_pkg::ST_BACK_PIV;
      gjr_pkg::ST_SCAN_RD:   state_next = gjr_pkg::ST_SCAN_CHK;
      gjr_pkg::ST_SCAN_CHK:
        if (!rd_zero) state_next = (t != prow) ? gjr_pkg::ST_SWAP_RD_T : gjr_pkg::ST_PIV_RD;
        else if (t + ONE == row_cnt) state_next = gjr_pkg::ST_COL;
        else state_next = gjr_pkg::ST_SCAN_RD;
      gjr_pkg::ST_SWAP_RD_T: state_next = gjr_pkg::ST_SWAP_RD_R;
      gjr_pkg::ST_SWAP_RD_R: state_next = gjr_pkg::ST_SWAP_WR_T;
      gjr_pkg::ST_SWAP_WR_T: state_next = gjr_pkg::ST_SWAP_WR_R;
      gjr_pkg::ST_SWAP_WR_R:
        state_next = (j + ONE == col_cnt) ? gjr_pkg::ST_PIV_RD : gjr_pkg::ST_SWAP_RD_T;
      gjr_pkg::ST_PIV_RD:    state_next = gjr_pkg::ST_PIV_SET;
      gjr_pkg::ST_PIV_SET:   state_next = gjr_pkg::ST_ELIM_ROW;
      gjr_pkg::ST_ELIM_ROW:
        state_next = (cur_i >= row_cnt) ? gjr_pkg::ST_COL : gjr_pkg::ST_ELIM_DIV;
      gjr_pkg::ST_ELIM_DIV:  state_next = gjr_pkg::ST_ELIM_WAIT;
      gjr_pkg::ST_ELIM_WAIT:
        if (div_done) state_next = gjr_pkg::ST_UPD_RD_S;
      gjr_pkg::ST_UPD_RD_S:  state_next = gjr_pkg::ST_UPD_RD_D;
      gjr_pkg::ST_UPD_RD_D:  state_next = gjr_pkg::ST_UPD_MUL;
      gjr_pkg::ST_UPD_MUL:   state_next = gjr_pkg::ST_UPD_SCALE;
      gjr_pkg::ST_UPD_SCALE: state_next = gjr_pkg::ST_UPD_WR;
      gjr_pkg::ST_UPD_WR:
        if (j + ONE == col_cnt)
          state_next = back ? gjr_pkg::ST_BACK_ROW : gjr_pkg::ST_ELIM_ROW;
        else
          state_next = gjr_pkg::ST_UPD_RD_S;
      gjr_pkg::ST_BACK_PIV:
        state_next = (k == '0) ? gjr_pkg::ST_EMIT : gjr_pkg::ST_BACK_PIV_SET;
      gjr_pkg::ST_BACK_PIV_SET: state_next = gjr_pkg::ST_BACK_ROW;
      gjr_pkg::ST_BACK_ROW:
        state_next = (cur_i == '0) ? gjr_pkg::ST_NORM_RD : gjr_pkg::ST_BACK_DIV;
      gjr_pkg::ST_BACK_DIV:  state_next = gjr_pkg::ST_BACK_WAIT;
      gjr_pkg::ST_BACK_WAIT:
        if (div_done) state_next = gjr_pkg::ST_UPD_RD_S;
      gjr_pkg::ST_NORM_RD:
        state_next = (j == col_cnt) ? gjr_pkg::ST_BACK_PIV : gjr_pkg::ST_NORM_DIV;
      gjr_pkg::ST_NORM_DIV:  state_next = gjr_pkg::ST_NORM_WAIT;
      gjr_pkg::ST_NORM_WAIT:
        if (div_done) state_next = gjr_pkg::ST_NORM_RD;
      gjr_pkg::ST_EMIT:
        if (emit_last) state_next = gjr_pkg::ST_LOAD;
      default: state_next = gjr_pkg::ST_LOAD;
    endcase
  end

  // memory port per state
  always_comb begin
    raddr = '0;
    waddr = '0;
    we    = 1'b0;
    wdata = element_value;
    case (state)
      gjr_pkg::ST_LOAD: begin
        waddr = load_count[gjr_pkg::AW-1:0];
        we    = accept;
        wdata = element_value;
      end
      gjr_pkg::ST_SCAN_RD:   raddr = gjr_pkg::cell_addr(t, col, col_cnt);
      gjr_pkg::ST_SWAP_RD_T: raddr = gjr_pkg::cell_addr(t, j, col_cnt);
      gjr_pkg::ST_SWAP_RD_R: raddr = gjr_pkg::cell_addr(prow, j, col_cnt);
      gjr_pkg::ST_SWAP_WR_T: begin
        waddr = gjr_pkg::cell_addr(t, j, col_cnt);
        we    = 1'b1;
        wdata = rdata;
      end
      gjr_pkg::ST_SWAP_WR_R: begin
        waddr = gjr_pkg::cell_addr(prow, j, col_cnt);
        we    = 1'b1;
        wdata = tmp;
      end
      gjr_pkg::ST_PIV_RD:    raddr = gjr_pkg::cell_addr(prow, col, col_cnt);
      gjr_pkg::ST_ELIM_ROW:  raddr = gjr_pkg::cell_addr(cur_i, col, col_cnt);
      gjr_pkg::ST_UPD_RD_S:  raddr = gjr_pkg::cell_addr(src_row, j, col_cnt);
      gjr_pkg::ST_UPD_RD_D:  raddr = gjr_pkg::cell_addr(dst_row, j, col_cnt);
      gjr_pkg::ST_UPD_WR: begin
        waddr = gjr_pkg::cell_addr(dst_row, j, col_cnt);
        we    = 1'b1;
        wdata = upd_val;
      end
      gjr_pkg::ST_BACK_PIV:
        raddr = gjr_pkg::cell_addr(km1, gjr_pkg::CNT_W'(pivcols[km1[gjr_pkg::RIW-1:0]]),
                                   col_cnt);
      gjr_pkg::ST_BACK_ROW:  raddr = gjr_pkg::cell_addr(cur_i - ONE, pcol, col_cnt);
      gjr_pkg::ST_NORM_RD:   raddr = gjr_pkg::cell_addr(pr, j, col_cnt);
      gjr_pkg::ST_NORM_WAIT: begin
        waddr = gjr_pkg::cell_addr(pr, j, col_cnt);
        we    = div_done;
        wdata = div_q;
      end
      gjr_pkg::ST_EMIT:      raddr = gjr_pkg::cell_addr(cur_i, j, col_cnt);
      default: raddr = '0;
    endcase
  end

  // matrix store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // control state, counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gjr_pkg::ST_LOAD;
      row_cnt      <= gjr_pkg::RESET_ROWS;
      col_cnt      <= gjr_pkg::RESET_COLS;
      thr          <= gjr_pkg::RESET_THR;
      load_count   <= '0;
      prow         <= '0;
      col          <= '0;
      t            <= '0;
      cur_i        <= '0;
      j            <= '0;
      k            <= '0;
      pr           <= '0;
      pcol         <= '0;
      pcnt         <= '0;
      back         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= state == gjr_pkg::ST_EMIT;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gjr_pkg::REG_ROW_COUNT:
            row_cnt <= gjr_pkg::clamp_count(cfg_data[gjr_pkg::COUNT_IN_W-1:0],
                                            gjr_pkg::MAX_ROWS);
          gjr_pkg::REG_COL_COUNT:
            col_cnt <= gjr_pkg::clamp_count(cfg_data[gjr_pkg::COUNT_IN_W-1:0],
                                            gjr_pkg::MAX_COLS);
          gjr_pkg::REG_ZERO_THRESHOLD:
            thr <= cfg_data[gjr_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      case (state)
        gjr_pkg::ST_LOAD:
          if (accept) begin
            if (load_done) begin
              load_count <= '0;
              prow       <= '0;
              col        <= '0;
              pcnt       <= '0;
            end else begin
              load_count <= lc_inc;
            end
          end
        gjr_pkg::ST_COL:
          if (col < col_cnt && prow < row_cnt) t <= prow;
          else k <= pcnt;
        gjr_pkg::ST_SCAN_CHK:
          if (!rd_zero) j <= '0;
          else if (t + ONE == row_cnt) col <= col + ONE;
          else t <= t + ONE;
        gjr_pkg::ST_SWAP_WR_R: j <= j + ONE;
        gjr_pkg::ST_PIV_SET: begin
          pcnt  <= pcnt + ONE;
          cur_i <= prow + ONE;
        end
        gjr_pkg::ST_ELIM_ROW:
          if (cur_i >= row_cnt) begin
            prow <= prow + ONE;
            col  <= col + ONE;
          end
        gjr_pkg::ST_ELIM_WAIT:
          if (div_done) begin
            j    <= col;
            back <= 1'b0;
          end
        gjr_pkg::ST_UPD_WR:
          if (j + ONE == col_cnt) cur_i <= back ? cur_i - ONE : cur_i + ONE;
          else j <= j + ONE;
        gjr_pkg::ST_BACK_PIV:
          if (k == '0) begin
            cur_i <= '0;
            j     <= '0;
          end else begin
            pr   <= km1;
            pcol <= gjr_pkg::CNT_W'(pivcols[km1[gjr_pkg::RIW-1:0]]);
          end
        gjr_pkg::ST_BACK_PIV_SET: cur_i <= pr;
        gjr_pkg::ST_BACK_ROW:
          if (cur_i == '0) j <= pcol;
        gjr_pkg::ST_BACK_WAIT:
          if (div_done) begin
            j    <= pcol;
            back <= 1'b1;
          end
        gjr_pkg::ST_NORM_RD:
          if (j == col_cnt) k <= km1;
        gjr_pkg::ST_NORM_WAIT:
          if (div_done) j <= j + ONE;
        gjr_pkg::ST_EMIT:
          if (j + ONE == col_cnt) begin
            j     <= '0;
            cur_i <= cur_i + ONE;
          end else begin
            j <= j + ONE;
          end
        default: ;
      endcase
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    case (state)
      gjr_pkg::ST_SWAP_RD_R: tmp <= rdata;
      gjr_pkg::ST_PIV_SET: begin
        piv <= rdata;
        pivcols[prow[gjr_pkg::RIW-1:0]] <= col[gjr_pkg::CIW-1:0];
      end
      gjr_pkg::ST_ELIM_WAIT, gjr_pkg::ST_BACK_WAIT:
        if (div_done) f <= div_q;
      gjr_pkg::ST_UPD_RD_D: opa <= rdata;
      gjr_pkg::ST_UPD_MUL: begin
        prod <= gjr_pkg::WIDE_W'(opa) * gjr_pkg::WIDE_W'(f);
        x    <= rdata;
      end
      gjr_pkg::ST_UPD_SCALE: qv <= gjr_pkg::sat_wide(adj >>> gjr_pkg::FRAC_BITS);
      gjr_pkg::ST_BACK_PIV_SET: piv <= rdata;
      default: ;
    endcase
    result_row <= 3'(cur_i);
    result_col <= 3'(j);
    is_last    <= emit_last;
  end

  assign result_value = rdata;

`ifndef ASSERT_OFF
  // the last element closes the transfer burst
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_last |=> !result_valid)
    else $error("result after last element");

  // every emit cycle yields one result transfer
  a_emit_strobe: assert property (@(posedge clk) disable iff (rst)
    state == gjr_pkg::ST_EMIT |=> result_valid)
    else $error("emit cycle without result");

  // divider results arrive only while the sequencer waits for one
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == gjr_pkg::ST_ELIM_WAIT || state == gjr_pkg::ST_BACK_WAIT ||
                  state == gjr_pkg::ST_NORM_WAIT))
    else $error("unexpected divider result");

  // no more pivots than rows
  a_pivot_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> pcnt <= row_cnt)
    else $error("pivot count beyond row count");
`endif

endmodule

[sv/gjr_div_cell.sv]
module gjr_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  gjr_pkg::div_stage_t din,
  output gjr_pkg::div_stage_t dout
);

  logic [gjr_pkg::DATA_W:0]   trial;
  logic [gjr_pkg::DATA_W:0]   diff;
  logic                       ge;
  logic [gjr_pkg::DATA_W-1:0] rem_next;
  logic [gjr_pkg::DQ_W-1:0]   dq_next;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {din.rem, din.dq[gjr_pkg::DQ_W-1]};
    diff     = trial - {1'b0, din.dvs};
    ge       = trial >= {1'b0, din.dvs};
    rem_next = ge ? diff[gjr_pkg::DATA_W-1:0] : trial[gjr_pkg::DATA_W-1:0];
    dq_next  = {din.dq[gjr_pkg::DQ_W-2:0], ge};
  end

  // valid travels with reset, partial remainder and quotient move to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.neg <= din.neg;
    dout.dz  <= din.dz;
    dout.nz  <= din.nz;
    dout.rem <= rem_next;
    dout.dq  <= dq_next;
    dout.dvs <= din.dvs;
  end

endmodule

[sv/gjr_div_chain.sv]
module gjr_div_chain (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  gjr_pkg::q_t dividend,
  input  gjr_pkg::q_t divisor,
  output logic        done,
  output gjr_pkg::q_t quotient
);

  gjr_pkg::div_stage_t stage [0:gjr_pkg::DIV_STEPS];
  gjr_pkg::div_stage_t last;
  logic [gjr_pkg::DQ_W-1:0]   q;
  logic [gjr_pkg::DATA_W-1:0] q_neg;
  logic                       q_big;

  // operands as magnitudes, dividend scaled by one in Q format
  always_comb begin
    stage[0].valid = go;
    stage[0].neg   = dividend[gjr_pkg::DATA_W-1] ^ divisor[gjr_pkg::DATA_W-1];
    stage[0].dz    = divisor == '0;
    stage[0].nz    = dividend != '0;
    stage[0].rem   = '0;
    stage[0].dq    = {gjr_pkg::magnitude(dividend), {gjr_pkg::FRAC_BITS{1'b0}}};
    stage[0].dvs   = gjr_pkg::magnitude(divisor);
  end

  // row of one-bit divider cells
  for (genvar i = 0; i < gjr_pkg::DIV_STEPS; i++) begin : g_cell
    gjr_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (stage[i]),
      .dout (stage[i+1])
    );
  end

  // sign, saturation and the zero divisor case
  always_comb begin
    last     = stage[gjr_pkg::DIV_STEPS];
    q        = last.dq;
    q_big    = |q[gjr_pkg::DQ_W-1:gjr_pkg::DATA_W];
    q_neg    = ~q[gjr_pkg::DATA_W-1:0] + 1'b1;
    done     = last.valid;
    if (last.dz) begin
      if (!last.nz) quotient = '0;
      else quotient = last.neg ? gjr_pkg::Q_MIN : gjr_pkg::Q_MAX;
    end else if (last.neg) begin
      if (q_big || (q[gjr_pkg::DATA_W-1] && |q[gjr_pkg::DATA_W-2:0]))
        quotient = gjr_pkg::Q_MIN;
      else
        quotient = q_neg;
    end else begin
      if (q_big || q[gjr_pkg::DATA_W-1]) quotient = gjr_pkg::Q_MAX;
      else quotient = q[gjr_pkg::DATA_W-1:0];
    end
  end

endmodule
